// File: rtl/core/assert_macros.svh
// shared assertion macros, clocked on clock and quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pn3d_pkg.sv
`default_nettype none

package pn3d_pkg;

   // request command codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   // fade polynomial 6t^5 - 15t^4 + 10t^3 in nested form
   localparam int FADE_MUL = 6;
   localparam int FADE_SUB = 15;
   localparam int FADE_ADD = 10;

   localparam int BYTE_BITS  = 8;
   localparam int NOISE_BITS = 16;

endpackage

`default_nettype wire

// File: rtl/core/pn3d_fade.sv
`default_nettype none

module pn3d_fade
   import pn3d_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire logic [FRAC_BITS-1:0]   frac,
   output logic signed [FRAC_BITS+1:0] fade
);

   localparam int F  = FRAC_BITS;
   localparam int FW = F + 2;
   localparam int KW = F + 5;
   localparam int PW = 2 * F + 7;

   localparam logic signed [PW-1:0] HALF_P = PW'(64'd1 << (F - 1));
   localparam logic signed [KW-1:0] ONE_K  = KW'(64'd1 << F);

   logic signed [PW-1:0] t_in;
   logic signed [KW-1:0] k_in;
   logic signed [PW-1:0] p_tt;
   logic signed [PW-1:0] p_k;
   logic signed [PW-1:0] p_c;
   logic signed [PW-1:0] p_f;

   logic [F-1:0]         t_ff;
   logic [F:0]           tt_ff;
   logic signed [KW-1:0] pk_ff;
   logic [F:0]           cube_ff;
   logic signed [KW-1:0] inner_ff;
   logic signed [FW-1:0] fade_ff;

   // first stage: t*t and t*(6t-15)
   always_comb begin
      t_in = $signed({{(PW-F){1'b0}}, frac});
      k_in = $signed({5'd0, frac}) * KW'(FADE_MUL) - ONE_K * KW'(FADE_SUB);
      p_tt = t_in * t_in + HALF_P;
      p_k  = t_in * PW'(k_in) + HALF_P;
   end

   // second stage: cube and inner term
   always_comb begin
      p_c = $signed({{(PW-F-1){1'b0}}, tt_ff}) * $signed({{(PW-F){1'b0}}, t_ff}) + HALF_P;
   end

   // third stage: cube times inner term
   always_comb begin
      p_f = $signed({{(PW-F-1){1'b0}}, cube_ff}) * PW'(inner_ff) + HALF_P;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff     <= frac;
         tt_ff    <= p_tt[2*F:F];
         pk_ff    <= p_k[F+KW-1:F];
         cube_ff  <= p_c[2*F:F];
         inner_ff <= pk_ff + ONE_K * KW'(FADE_ADD);
         fade_ff  <= p_f[F+FW-1:F];
      end
   end

   assign fade = fade_ff;

endmodule

`default_nettype wire

// File: rtl/core/perlin_noise_3d_fixed_unit.sv
// an evaluate transfer on req runs through all DEPTH stages to its result on rsp
// throughput: one evaluate per cycle unless rsp stalls; a load waits while an evaluate
//    sits in the first stage, since the three table lookups span three stages
// reset: synchronous; then a fill of all TABLE_ENTRIES entries (entry i gets i & 255)
//    runs while req_stall is high; all stages stall while a result sits on a stalled rsp
`default_nettype none

`include "assert_macros.svh"

module perlin_noise_3d_fixed_unit
   import pn3d_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_command,
   input  wire logic [7:0]            req_entry_index,
   input  wire logic [7:0]            req_entry_value,
   input  wire logic signed [31:0]    req_coord_x,
   input  wire logic signed [31:0]    req_coord_y,
   input  wire logic signed [31:0]    req_coord_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [NOISE_BITS-1:0]      rsp_noise_value
);

   localparam int IB     = $clog2(TABLE_ENTRIES);
   localparam int F      = FRAC_BITS;
   localparam int FW     = F + 2;
   localparam int GW     = F + 3;
   localparam int VW     = F + 4;
   localparam int LW     = FW + VW + 1;
   localparam int COPIES = 7;
   localparam int DEPTH  = 8;
   localparam int SHR    = (F >= 15) ? F - 15 : 0;
   localparam int SHL    = (F < 15) ? 15 - F : 0;
   localparam int QW     = VW + 1 + SHL;

   localparam logic signed [GW-1:0]   ONE_G  = GW'(64'd1 << F);
   localparam logic signed [VW:0]     ONE_S  = (VW+1)'(64'd1 << F);
   localparam logic signed [LW-1:0]   HALF_L = LW'(64'd1 << (F - 1));

   // index wrap of a byte plus a cell index
   function automatic logic [IB-1:0] wrap_add(input logic [7:0] v, input logic [IB-1:0] c);
      logic [IB+7:0] s;
      s = (IB+8)'(v) + (IB+8)'(c);
      return s[IB-1:0];
   endfunction

   // one of twelve gradient directions dotted with the corner offset
   function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
         input logic signed [GW-1:0] gx, input logic signed [GW-1:0] gy,
         input logic signed [GW-1:0] gz);
      logic signed [GW-1:0] gu;
      logic signed [GW-1:0] gv;
      gu = (h < 4'd8) ? gx : gy;
      if (h < 4'd4)
         gv = gy;
      else if (h == 4'd12 || h == 4'd14)
         gv = gx;
      else
         gv = gz;
      if (h[0])
         gu = -gu;
      if (h[1])
         gv = -gv;
      return gu + gv;
   endfunction

   // a + round(t * (b - a))
   function automatic logic signed [VW-1:0] lerp(input logic signed [FW-1:0] t,
         input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
      logic signed [VW:0]   d;
      logic signed [LW-1:0] p;
      d = (VW+1)'(b) - (VW+1)'(a);
      p = LW'(t) * LW'(d) + HALF_L;
      return a + $signed(p[F+VW-1:F]);
   endfunction

   logic adv;
   logic load_acc;
   logic eval_acc;
   logic [DEPTH:1] v_ff;

   logic          clr_ff;
   logic [IB-1:0] clr_cnt_ff;
   logic [IB+7:0] clr_ext;
   logic [IB+7:0] load_ext;

   logic          tab_we;
   logic [IB-1:0] tab_waddr;
   logic [7:0]    tab_wdata;

   logic [IB-1:0] raddr [COPIES][2];
   logic [7:0]    rd_q  [COPIES][2];

   logic [32+IB-1:0] ext_x;
   logic [32+IB-1:0] ext_y;
   logic [32+IB-1:0] ext_z;
   logic [IB-1:0]    cx;
   logic [IB-1:0]    ha, hb, haa, hab, hba, hbb;

   logic [IB-1:0] cy1_ff, cz1_ff, cz2_ff;
   logic [F-1:0]  xf1_ff, yf1_ff, zf1_ff;
   logic [F-1:0]  xf2_ff, yf2_ff, zf2_ff;
   logic [F-1:0]  xf3_ff, yf3_ff, zf3_ff;

   logic signed [FW-1:0] fu, fv, fw;
   logic signed [FW-1:0] u4_ff, v4_ff, w4_ff, v5_ff, w5_ff, w6_ff;

   logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
   logic signed [GW-1:0] g_in [8];
   logic signed [GW-1:0] g_ff [8];
   logic signed [VW-1:0] l_ff [4];
   logic signed [VW-1:0] m_ff [2];
   logic signed [VW-1:0] r_ff;

   logic signed [VW:0]       s_in;
   logic [QW-1:0]            q_in;
   logic [NOISE_BITS-1:0]    noise_in;
   logic [NOISE_BITS-1:0]    noise_ff;

   // handshake and stage advance
   always_comb begin
      adv       = !(v_ff[DEPTH] && rsp_stall);
      req_stall = clr_ff || !adv || (cmd_type'(req_command) == CMD_LOAD && v_ff[1]);
      load_acc  = req_valid && !req_stall && cmd_type'(req_command) == CMD_LOAD;
      eval_acc  = req_valid && !req_stall && cmd_type'(req_command) == CMD_EVAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DEPTH-1:1], eval_acc};
      end
   end

   // table fill after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + IB'(1);
         if (clr_cnt_ff == IB'(TABLE_ENTRIES - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // table write port, shared by every copy
   always_comb begin
      clr_ext   = (IB+8)'(clr_cnt_ff);
      load_ext  = (IB+8)'(req_entry_index);
      tab_we    = clr_ff || load_acc;
      tab_waddr = clr_ff ? clr_cnt_ff : load_ext[IB-1:0];
      tab_wdata = clr_ff ? clr_ext[7:0] : req_entry_value;
   end

   // lookup addresses for the three hash levels
   always_comb begin
      ext_x = {{IB{req_coord_x[31]}}, req_coord_x};
      cx    = ext_x[F+IB-1:F];
      ha    = wrap_add(rd_q[0][0], cy1_ff);
      hb    = wrap_add(rd_q[0][1], cy1_ff);
      haa   = wrap_add(rd_q[1][0], cz2_ff);
      hab   = wrap_add(rd_q[1][1], cz2_ff);
      hba   = wrap_add(rd_q[2][0], cz2_ff);
      hbb   = wrap_add(rd_q[2][1], cz2_ff);
      raddr[0][0] = cx;
      raddr[0][1] = cx + IB'(1);
      raddr[1][0] = ha;
      raddr[1][1] = ha + IB'(1);
      raddr[2][0] = hb;
      raddr[2][1] = hb + IB'(1);
      raddr[3][0] = haa;
      raddr[3][1] = haa + IB'(1);
      raddr[4][0] = hab;
      raddr[4][1] = hab + IB'(1);
      raddr[5][0] = hba;
      raddr[5][1] = hba + IB'(1);
      raddr[6][0] = hbb;
      raddr[6][1] = hbb + IB'(1);
   end

   // permutation table copies, one per lookup pair
   for (genvar gi = 0; gi < COPIES; gi++) begin : g_copy
      logic [7:0] tab_mem [TABLE_ENTRIES];
      logic [7:0] lo_ff;
      logic [7:0] hi_ff;

      always_ff @(posedge clock) begin
         if (tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
         end
         if (adv) begin
            lo_ff <= tab_mem[raddr[gi][0]];
            hi_ff <= tab_mem[raddr[gi][1]];
         end
      end

      assign rd_q[gi][0] = lo_ff;
      assign rd_q[gi][1] = hi_ff;
   end

   // fade curves, three stages each
   pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock(clock), .enable(adv), .frac(req_coord_x[F-1:0]), .fade(fu));
   pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock(clock), .enable(adv), .frac(req_coord_y[F-1:0]), .fade(fv));
   pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
      .clock(clock), .enable(adv), .frac(req_coord_z[F-1:0]), .fade(fw));

   // corner gradients
   always_comb begin
      x0 = $signed({3'd0, xf3_ff});
      y0 = $signed({3'd0, yf3_ff});
      z0 = $signed({3'd0, zf3_ff});
      x1 = x0 - ONE_G;
      y1 = y0 - ONE_G;
      z1 = z0 - ONE_G;
      g_in[0] = grad(rd_q[3][0][3:0], x0, y0, z0);
      g_in[1] = grad(rd_q[5][0][3:0], x1, y0, z0);
      g_in[2] = grad(rd_q[4][0][3:0], x0, y1, z0);
      g_in[3] = grad(rd_q[6][0][3:0], x1, y1, z0);
      g_in[4] = grad(rd_q[3][1][3:0], x0, y0, z1);
      g_in[5] = grad(rd_q[5][1][3:0], x1, y0, z1);
      g_in[6] = grad(rd_q[4][1][3:0], x0, y1, z1);
      g_in[7] = grad(rd_q[6][1][3:0], x1, y1, z1);
   end

   // normalise (res+1)/2 to unsigned 16-bit with saturation
   always_comb begin
      s_in = (VW+1)'(r_ff) + ONE_S;
      q_in = QW'(unsigned'(s_in) >> SHR) << SHL;
      if (s_in[VW] || s_in == '0)
         noise_in = '0;
      else if (|q_in[QW-1:NOISE_BITS])
         noise_in = '1;
      else
         noise_in = q_in[NOISE_BITS-1:0];
   end

   // data stages
   always_ff @(posedge clock) begin
      if (adv) begin
         cy1_ff <= ext_y[F+IB-1:F];
         xf1_ff <= req_coord_x[F-1:0];
         yf1_ff <= req_coord_y[F-1:0];
         zf1_ff <= req_coord_z[F-1:0];
         cz2_ff <= cz1_ff;
         xf2_ff <= xf1_ff;
         yf2_ff <= yf1_ff;
         zf2_ff <= zf1_ff;
         xf3_ff <= xf2_ff;
         yf3_ff <= yf2_ff;
         zf3_ff <= zf2_ff;
         u4_ff  <= fu;
         v4_ff  <= fv;
         w4_ff  <= fw;
         for (int i = 0; i < 8; i++) begin
            g_ff[i] <= g_in[i];
         end
         l_ff[0] <= lerp(u4_ff, VW'(g_ff[0]), VW'(g_ff[1]));
         l_ff[1] <= lerp(u4_ff, VW'(g_ff[2]), VW'(g_ff[3]));
         l_ff[2] <= lerp(u4_ff, VW'(g_ff[4]), VW'(g_ff[5]));
         l_ff[3] <= lerp(u4_ff, VW'(g_ff[6]), VW'(g_ff[7]));
         v5_ff   <= v4_ff;
         w5_ff   <= w4_ff;
         m_ff[0] <= lerp(v5_ff, l_ff[0], l_ff[1]);
         m_ff[1] <= lerp(v5_ff, l_ff[2], l_ff[3]);
         w6_ff   <= w5_ff;
         r_ff    <= lerp(w6_ff, m_ff[0], m_ff[1]);
         noise_ff <= noise_in;
      end
   end

   // cell indices of y and z, wrapped to the table size
   assign ext_y = {{IB{req_coord_y[31]}}, req_coord_y};
   assign ext_z = {{IB{req_coord_z[31]}}, req_coord_z};

   always_ff @(posedge clock) begin
      if (adv) begin
         cz1_ff <= ext_z[F+IB-1:F];
      end
   end

   assign rsp_valid       = v_ff[DEPTH];
   assign rsp_noise_value = noise_ff;

   `ASSERT_SAME(a_fill_blocks_req, clr_ff, req_stall,
      "transfer possible during table fill")
   `ASSERT_NEXT(a_last_stage_reaches_rsp, adv && v_ff[DEPTH-1], rsp_valid,
      "evaluate lost between last stage and rsp")
   `ASSERT_SAME(a_fill_length, $fell(clr_ff),
      $past(clr_cnt_ff) == IB'(TABLE_ENTRIES - 1), "table fill ended early")

endmodule

`default_nettype wire
